// ===== rtl/buddy_block_allocator_core_assert.svh =====
// Assertion macros for the buddy block allocator core.
// Included by rtl modules that carry concurrent checks; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bba check failed");
// Next-cycle implication, disabled while reset is low
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bba check failed");
`else
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bba_pkg.sv =====
// Shared constants, types and helper functions for the buddy block allocator.
// No dependencies; used by the top level buddy_block_allocator_core.
package bba_pkg;

  localparam int POOL_ORDER      = 16;
  localparam int MIN_BLOCK_ORDER = 5;
  localparam int HEADER_BYTES    = 16;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int ORD_W      = 5;
  localparam int USED_W     = 17;
  localparam int STAT_W     = 2;
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Tree geometry: level 0 is the whole pool, level LEVELS the minimum blocks
  localparam int LEVELS     = POOL_ORDER - MIN_BLOCK_ORDER;
  localparam int NUM_LVL    = LEVELS + 1;
  localparam int LVL_W      = $clog2(NUM_LVL + 1);
  localparam int IDX_W      = LEVELS;
  localparam int CNT_W      = LEVELS + 1;
  localparam int WORD_LOG   = 5;
  localparam int WORD_W     = 2 ** WORD_LOG;
  localparam int MAP_WORDS  = (LEVELS > WORD_LOG) ?
                              (2 ** (LEVELS - WORD_LOG + 1) + WORD_LOG - 1) : (LEVELS + 1);
  localparam int MAP_AW     = $clog2(MAP_WORDS);
  localparam int SLOT_DEPTH = 2 ** LEVELS;
  localparam int SLOT_AW    = LEVELS;
  localparam int CODE_W     = $clog2(LEVELS + 2);
  localparam int CLR_DEPTH  = (SLOT_DEPTH > MAP_WORDS) ? SLOT_DEPTH : MAP_WORDS;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  localparam int RESET_ORDER = 16;
  localparam int RESET_EFF   = (RESET_ORDER < MIN_BLOCK_ORDER) ? MIN_BLOCK_ORDER :
                               (RESET_ORDER > POOL_ORDER) ? POOL_ORDER : RESET_ORDER;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_ORDER = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ORDER,
    S_SEARCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPL_RD,
    S_SPL_WR,
    S_ALLOC_FIN,
    S_FREE_OFF,
    S_FREE_RD,
    S_FREE_CHK,
    S_MRG_RD,
    S_MRG_CHK,
    S_RESP
  } state_t;

  // Clamp a written region order into the supported range
  function automatic logic [ORD_W-1:0] sat_order(input logic [ORD_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = v;
    if (int'(v) < MIN_BLOCK_ORDER) r = ORD_W'(MIN_BLOCK_ORDER);
    if (int'(v) > POOL_ORDER) r = ORD_W'(POOL_ORDER);
    return r;
  endfunction

  // Free-map word that holds block idx of tree level lvl
  function automatic logic [MAP_AW-1:0] map_word(input logic [LVL_W-1:0] lvl,
                                                 input logic [IDX_W-1:0] idx);
    logic [MAP_AW-1:0] w;
    if (int'(lvl) <= WORD_LOG) begin
      w = MAP_AW'(lvl);
    end else begin
      w = MAP_AW'((1 << (int'(lvl) - WORD_LOG)) + WORD_LOG - 1 + int'(idx >> WORD_LOG));
    end
    return w;
  endfunction

  // Bit position of block idx inside its free-map word
  function automatic logic [WORD_LOG-1:0] map_bit(input logic [IDX_W-1:0] idx);
    return WORD_LOG'(idx);
  endfunction

endpackage

// ===== rtl/buddy_block_allocator_core.sv =====
// Allocate: round the size up to an order, search the counts, scan map words, split blocks;
// free: check the offset, look up the order, merge buddies; zero size answers with no search.
// One request in flight at a time; every scan, split and merge step uses the free-map RAM.
// Reset (rst_n low, synchronous) and any region_order write start a clearing pass over
// all 2048 order-table slots and the free map, during which no request is taken.
// Config writes are taken in every cycle; a result waits in the output register.
module buddy_block_allocator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]   in_tdata,   // request_size, block_address
  input  logic [bba_pkg::IN_USER_W-1:0]   in_tuser,   // req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]  out_tdata,  // granted_address, granted_order,
                                                      // used_bytes
  output logic [bba_pkg::OUT_USER_W-1:0]  out_tuser,  // status
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

`include "buddy_block_allocator_core_assert.svh"

  bba_pkg::state_t                  state_r, state_nxt;
  logic [bba_pkg::CLR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [bba_pkg::ADDR_W-1:0]       base_r, base_nxt;
  logic [bba_pkg::ORD_W-1:0]        eff_r, eff_nxt;
  logic [bba_pkg::USED_W-1:0]       used_r, used_nxt;
  logic [bba_pkg::CNT_W-1:0]        cnt_r [bba_pkg::NUM_LVL];
  logic [bba_pkg::CNT_W-1:0]        cnt_nxt [bba_pkg::NUM_LVL];
  logic [bba_pkg::ADDR_W-1:0]       opnd_r, opnd_nxt;
  logic [bba_pkg::SIZE_W-1:0]       tsz_r, tsz_nxt;
  logic [bba_pkg::ORD_W-1:0]        need_r, need_nxt;
  logic [bba_pkg::ORD_W-1:0]        cur_r, cur_nxt;
  logic [bba_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [bba_pkg::MAP_AW-1:0]       word_r, word_nxt;
  logic [bba_pkg::ADDR_W-1:0]       off_r, off_nxt;
  logic [bba_pkg::ADDR_W-1:0]       res_addr_r, res_addr_nxt;
  bba_pkg::status_t                 res_stat_r, res_stat_nxt;
  logic [bba_pkg::ORD_W-1:0]        res_ord_r, res_ord_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bba_pkg::ADDR_W-1:0]       out_addr_r, out_addr_nxt;
  bba_pkg::status_t                 out_stat_r, out_stat_nxt;
  logic [bba_pkg::ORD_W-1:0]        out_ord_r, out_ord_nxt;
  logic [bba_pkg::USED_W-1:0]       out_used_r, out_used_nxt;

  logic                             map_we;
  logic [bba_pkg::MAP_AW-1:0]       map_waddr, map_raddr;
  logic [bba_pkg::WORD_W-1:0]       map_wdata, map_rdata;
  logic                             tbl_we;
  logic [bba_pkg::SLOT_AW-1:0]      tbl_waddr, tbl_raddr;
  logic [bba_pkg::CODE_W-1:0]       tbl_wdata, tbl_rdata;

  logic                             cnt_inc, cnt_dec;
  logic [bba_pkg::LVL_W-1:0]        cur_lvl;
  logic                             srch_hit;
  logic [bba_pkg::ORD_W-1:0]        srch_ord;
  logic [bba_pkg::WORD_LOG-1:0]     low_pos;
  logic [bba_pkg::MAP_AW-1:0]       lvl_base;
  logic [bba_pkg::ADDR_W-1:0]       alloc_off;
  logic [bba_pkg::ADDR_W-1:0]       free_off;
  logic [bba_pkg::ORD_W-1:0]        free_ord;
  logic [bba_pkg::ORD_W-1:0]        cfg_eff;
  logic [bba_pkg::SIZE_W-1:0]       pad_size;
  logic                             in_xfer;

  bba_ram #(.WIDTH(bba_pkg::WORD_W), .DEPTH(bba_pkg::MAP_WORDS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  bba_ram #(.WIDTH(bba_pkg::CODE_W), .DEPTH(bba_pkg::SLOT_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign in_tready  = (state_r == bba_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {{(bba_pkg::OUT_DATA_W - bba_pkg::ADDR_W - bba_pkg::ORD_W
                         - bba_pkg::USED_W){1'b0}}, out_used_r, out_ord_r, out_addr_r};

  // Working values of the current step
  assign cur_lvl   = bba_pkg::LVL_W'(bba_pkg::POOL_ORDER - int'(cur_r));
  assign lvl_base  = bba_pkg::map_word(cur_lvl, '0);
  assign alloc_off = bba_pkg::ADDR_W'(idx_r) << need_r;
  assign free_off  = opnd_r - bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES) - base_r;
  assign free_ord  = bba_pkg::ORD_W'(int'(tbl_rdata) + bba_pkg::MIN_BLOCK_ORDER - 1);
  assign cfg_eff   = bba_pkg::sat_order(cfg_wdata[bba_pkg::ORD_W-1:0]);
  assign pad_size  = bba_pkg::SIZE_W'(in_tdata[bba_pkg::ADDR_W-1:0])
                     + bba_pkg::SIZE_W'(bba_pkg::HEADER_BYTES - 1);

  // Pick the smallest order at or above the need that still has a free block
  always_comb begin
    srch_hit = 1'b0;
    srch_ord = '0;
    for (int k = 0; k < bba_pkg::NUM_LVL; k++) begin
      if (cnt_r[k] != '0 && (bba_pkg::POOL_ORDER - k) >= int'(need_r) &&
          (bba_pkg::POOL_ORDER - k) <= int'(eff_r)) begin
        srch_hit = 1'b1;
        srch_ord = bba_pkg::ORD_W'(bba_pkg::POOL_ORDER - k);
      end
    end
  end

  // Lowest set bit of the word just read
  always_comb begin
    low_pos = '0;
    for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (map_rdata[b]) low_pos = bba_pkg::WORD_LOG'(b);
    end
  end

  // Sequencer: next state, datapath updates, RAM controls
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    base_nxt     = base_r;
    eff_nxt      = eff_r;
    used_nxt     = used_r;
    opnd_nxt     = opnd_r;
    tsz_nxt      = tsz_r;
    need_nxt     = need_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    word_nxt     = word_r;
    off_nxt      = off_r;
    res_addr_nxt = res_addr_r;
    res_stat_nxt = res_stat_r;
    res_ord_nxt  = res_ord_r;
    out_addr_nxt = out_addr_r;
    out_stat_nxt = out_stat_r;
    out_ord_nxt  = out_ord_r;
    out_used_nxt = out_used_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    map_we       = 1'b0;
    map_waddr    = word_r;
    map_wdata    = map_rdata;
    map_raddr    = word_r;
    tbl_we       = 1'b0;
    tbl_waddr    = bba_pkg::SLOT_AW'(off_r >> bba_pkg::MIN_BLOCK_ORDER);
    tbl_wdata    = '0;
    tbl_raddr    = bba_pkg::SLOT_AW'(off_r >> bba_pkg::MIN_BLOCK_ORDER);

    unique case (state_r)
      // Sweep both stores; the region root word gets its free bit
      bba_pkg::S_CLEAR: begin
        if ({1'b0, clr_cnt_r} < (bba_pkg::CLR_W + 1)'(bba_pkg::MAP_WORDS)) begin
          map_we    = 1'b1;
          map_waddr = clr_cnt_r[bba_pkg::MAP_AW-1:0];
          map_wdata = (clr_cnt_r[bba_pkg::MAP_AW-1:0] == bba_pkg::map_word(
                        bba_pkg::LVL_W'(bba_pkg::POOL_ORDER - int'(eff_r)), '0)) ?
                      bba_pkg::WORD_W'(1) : '0;
        end
        tbl_we      = 1'b1;
        tbl_waddr   = clr_cnt_r[bba_pkg::SLOT_AW-1:0];
        tbl_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == bba_pkg::CLR_W'(bba_pkg::CLR_DEPTH - 1)) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      // Take a request
      bba_pkg::S_IDLE: begin
        if (in_xfer) begin
          res_addr_nxt = '0;
          res_ord_nxt  = '0;
          res_stat_nxt = bba_pkg::ST_OK;
          if (in_tuser[0] == bba_pkg::REQ_FREE) begin
            opnd_nxt  = in_tdata[2*bba_pkg::ADDR_W-1:bba_pkg::ADDR_W];
            state_nxt = bba_pkg::S_FREE_OFF;
          end else if (in_tdata[bba_pkg::ADDR_W-1:0] == '0) begin
            res_stat_nxt = bba_pkg::ST_ZERO;
            state_nxt    = bba_pkg::S_RESP;
          end else begin
            tsz_nxt   = pad_size >> bba_pkg::MIN_BLOCK_ORDER;
            need_nxt  = bba_pkg::ORD_W'(bba_pkg::MIN_BLOCK_ORDER);
            state_nxt = bba_pkg::S_ORDER;
          end
        end
      end
      // Round the padded size up to an order, one bit a cycle; too large for the region is NOMEM
      bba_pkg::S_ORDER: begin
        if (tsz_r == '0) begin
          state_nxt = bba_pkg::S_SEARCH;
        end else if (need_r >= eff_r) begin
          res_stat_nxt = bba_pkg::ST_NOMEM;
          state_nxt    = bba_pkg::S_RESP;
        end else begin
          tsz_nxt  = tsz_r >> 1;
          need_nxt = need_r + 1'b1;
        end
      end
      bba_pkg::S_SEARCH: begin
        if (srch_hit) begin
          cur_nxt   = srch_ord;
          word_nxt  = bba_pkg::map_word(
                        bba_pkg::LVL_W'(bba_pkg::POOL_ORDER - int'(srch_ord)), '0);
          state_nxt = bba_pkg::S_SCAN_RD;
        end else begin
          res_stat_nxt = bba_pkg::ST_NOMEM;
          state_nxt    = bba_pkg::S_RESP;
        end
      end
      bba_pkg::S_SCAN_RD: begin
        map_raddr = word_r;
        state_nxt = bba_pkg::S_SCAN_CHK;
      end
      // Take the lowest free block found, or advance to the next word
      bba_pkg::S_SCAN_CHK: begin
        if (map_rdata != '0) begin
          map_we    = 1'b1;
          map_waddr = word_r;
          map_wdata = map_rdata & ~(bba_pkg::WORD_W'(1) << low_pos);
          cnt_dec   = 1'b1;
          idx_nxt   = bba_pkg::IDX_W'((int'(word_r - lvl_base) << bba_pkg::WORD_LOG)
                                      + int'(low_pos));
          if (cur_r > need_r) begin
            cur_nxt   = cur_r - 1'b1;
            idx_nxt   = bba_pkg::IDX_W'((int'(word_r - lvl_base) << bba_pkg::WORD_LOG)
                                        + int'(low_pos)) << 1;
            state_nxt = bba_pkg::S_SPL_RD;
          end else begin
            state_nxt = bba_pkg::S_ALLOC_FIN;
          end
        end else begin
          word_nxt  = word_r + 1'b1;
          state_nxt = bba_pkg::S_SCAN_RD;
        end
      end
      bba_pkg::S_SPL_RD: begin
        map_raddr = bba_pkg::map_word(cur_lvl, idx_r | bba_pkg::IDX_W'(1));
        state_nxt = bba_pkg::S_SPL_WR;
      end
      // Free the high half; keep splitting the low half
      bba_pkg::S_SPL_WR: begin
        map_we    = 1'b1;
        map_waddr = bba_pkg::map_word(cur_lvl, idx_r | bba_pkg::IDX_W'(1));
        map_wdata = map_rdata |
                    (bba_pkg::WORD_W'(1) << bba_pkg::map_bit(idx_r | bba_pkg::IDX_W'(1)));
        cnt_inc   = 1'b1;
        if (cur_r > need_r) begin
          cur_nxt   = cur_r - 1'b1;
          idx_nxt   = idx_r << 1;
          state_nxt = bba_pkg::S_SPL_RD;
        end else begin
          state_nxt = bba_pkg::S_ALLOC_FIN;
        end
      end
      // Record the order and answer
      bba_pkg::S_ALLOC_FIN: begin
        tbl_we       = 1'b1;
        tbl_waddr    = bba_pkg::SLOT_AW'(alloc_off >> bba_pkg::MIN_BLOCK_ORDER);
        tbl_wdata    = bba_pkg::CODE_W'(int'(need_r) - bba_pkg::MIN_BLOCK_ORDER + 1);
        used_nxt     = used_r + (bba_pkg::USED_W'(1) << need_r);
        res_addr_nxt = base_r + alloc_off + bba_pkg::ADDR_W'(bba_pkg::HEADER_BYTES);
        res_ord_nxt  = need_r;
        res_stat_nxt = bba_pkg::ST_OK;
        state_nxt    = bba_pkg::S_RESP;
      end
      bba_pkg::S_FREE_OFF: begin
        off_nxt   = free_off;
        state_nxt = bba_pkg::S_FREE_RD;
      end
      // Range and alignment check before the order lookup
      bba_pkg::S_FREE_RD: begin
        if ((off_r >> eff_r) == '0 && off_r[bba_pkg::MIN_BLOCK_ORDER-1:0] == '0) begin
          state_nxt = bba_pkg::S_FREE_CHK;
        end else begin
          res_stat_nxt = bba_pkg::ST_BADFREE;
          state_nxt    = bba_pkg::S_RESP;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        if (tbl_rdata == '0 ||
            int'(tbl_rdata) > int'(eff_r) - bba_pkg::MIN_BLOCK_ORDER + 1) begin
          res_stat_nxt = bba_pkg::ST_BADFREE;
          state_nxt    = bba_pkg::S_RESP;
        end else begin
          tbl_we      = 1'b1;
          tbl_wdata   = '0;
          cur_nxt     = free_ord;
          idx_nxt     = bba_pkg::IDX_W'(off_r >> free_ord);
          used_nxt    = used_r - (bba_pkg::USED_W'(1) << free_ord);
          res_ord_nxt = free_ord;
          state_nxt   = bba_pkg::S_MRG_RD;
        end
      end
      bba_pkg::S_MRG_RD: begin
        map_raddr = bba_pkg::map_word(cur_lvl, idx_r);
        state_nxt = bba_pkg::S_MRG_CHK;
      end
      // Absorb a free buddy and climb, or mark the block free and stop
      bba_pkg::S_MRG_CHK: begin
        map_we    = 1'b1;
        map_waddr = bba_pkg::map_word(cur_lvl, idx_r);
        if (cur_r < eff_r &&
            map_rdata[bba_pkg::map_bit(idx_r ^ bba_pkg::IDX_W'(1))]) begin
          map_wdata = map_rdata &
                      ~(bba_pkg::WORD_W'(1) << bba_pkg::map_bit(idx_r ^ bba_pkg::IDX_W'(1)));
          cnt_dec   = 1'b1;
          idx_nxt   = idx_r >> 1;
          cur_nxt   = cur_r + 1'b1;
          state_nxt = bba_pkg::S_MRG_RD;
        end else begin
          map_wdata = map_rdata | (bba_pkg::WORD_W'(1) << bba_pkg::map_bit(idx_r));
          cnt_inc   = 1'b1;
          state_nxt = bba_pkg::S_RESP;
        end
      end
      // Hand the result to the output register once it is free
      bba_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_stat_nxt  = res_stat_r;
          out_ord_nxt   = res_ord_r;
          out_used_nxt  = used_r;
          state_nxt     = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase

    // Per-order free block counts
    for (int k = 0; k < bba_pkg::NUM_LVL; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (k == int'(cur_lvl)) begin
        if (cnt_inc) cnt_nxt[k] = cnt_r[k] + 1'b1;
        else if (cnt_dec) cnt_nxt[k] = cnt_r[k] - 1'b1;
      end
    end

    // Configuration writes; a new region order restarts the clearing pass
    if (cfg_we) begin
      unique case (cfg_index)
        bba_pkg::REG_REGION_BASE: begin
          base_nxt = cfg_wdata[bba_pkg::ADDR_W-1:0];
        end
        bba_pkg::REG_REGION_ORDER: begin
          eff_nxt     = cfg_eff;
          used_nxt    = '0;
          clr_cnt_nxt = '0;
          state_nxt   = bba_pkg::S_CLEAR;
          for (int k = 0; k < bba_pkg::NUM_LVL; k++) begin
            cnt_nxt[k] = (k == bba_pkg::POOL_ORDER - int'(cfg_eff)) ?
                         bba_pkg::CNT_W'(1) : '0;
          end
        end
        default: begin
          base_nxt = base_r;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      base_r      <= '0;
      eff_r       <= bba_pkg::ORD_W'(bba_pkg::RESET_EFF);
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < bba_pkg::NUM_LVL; k++) begin
        cnt_r[k] <= (k == bba_pkg::POOL_ORDER - bba_pkg::RESET_EFF) ?
                    bba_pkg::CNT_W'(1) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      base_r      <= base_nxt;
      eff_r       <= eff_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < bba_pkg::NUM_LVL; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    opnd_r     <= opnd_nxt;
    tsz_r      <= tsz_nxt;
    need_r     <= need_nxt;
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    word_r     <= word_nxt;
    off_r      <= off_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    res_ord_r  <= res_ord_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
    out_ord_r  <= out_ord_nxt;
    out_used_r <= out_used_nxt;
  end

  `BBA_ASSERT_IMP(a_err_fields_zero, clk, rst_n, out_valid_r && out_stat_r != bba_pkg::ST_OK, out_addr_r == '0 && out_ord_r == '0)
  `BBA_ASSERT_IMP(a_ok_order_range, clk, rst_n, out_valid_r && out_stat_r == bba_pkg::ST_OK, int'(out_ord_r) >= bba_pkg::MIN_BLOCK_ORDER && int'(out_ord_r) <= bba_pkg::POOL_ORDER)
  `BBA_ASSERT_IMP(a_scan_has_block, clk, rst_n, state_r == bba_pkg::S_SCAN_RD, cnt_r[cur_lvl] != '0)
  `BBA_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_xfer, !in_tready)
  `BBA_ASSERT_IMP(a_used_in_pool, clk, rst_n, out_valid_r, 64'(out_used_r) <= (64'(1) << bba_pkg::POOL_ORDER))

endmodule

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the free map and the allocation order table.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
